>>> rtl/gosc_pkg.sv
// Package for the Gold/OVSF spreading code generator: widths, register
// indexes, the result type and the bit-reversal helper.
// No dependencies.
package gosc_pkg;

  localparam int unsigned LfsrBits     = 25;
  localparam int unsigned MaxLogSpread = 8;
  localparam int unsigned IdxW         = 8;
  localparam int unsigned LogW         = 4;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned CfgDataW     = 25;

  typedef enum logic [CfgIdxW-1:0] {
    CfgGoldSeed  = 2'd0,
    CfgCodeIndex = 2'd1,
    CfgLogSpread = 2'd2,
    CfgSeqLength = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic bad_config;
    logic last;
    logic chip;
  } result_t;

  function automatic logic [IdxW-1:0] reverse_idx(input logic [IdxW-1:0] v);
    logic [IdxW-1:0] r;
    for (int i = 0; i < IdxW; i++) begin
      r[i] = v[IdxW-1-i];
    end
    return r;
  endfunction

endpackage

>>> rtl/gosc_chip_calc.sv
// OVSF chip combination for the Gold/OVSF generator: effective spreading
// factor, configuration check and the combined chip for one position.
// Depends on gosc_pkg.
module gosc_chip_calc import gosc_pkg::*; (
  input  logic            gold_bit_i,
  input  logic [IdxW-1:0] pos_low_i,
  input  logic [IdxW-1:0] code_index_i,
  input  logic [LogW-1:0] log_spread_i,
  output logic            chip_o,
  output logic            bad_config_o
);

  logic            too_large;
  logic [LogW-1:0] eff_log;
  logic [LogW-1:0] rev_shift;
  logic [IdxW-1:0] rev_code;
  logic [IdxW-1:0] high_bits;

  assign too_large = log_spread_i > LogW'(MaxLogSpread);
  assign eff_log   = too_large ? LogW'(MaxLogSpread) : log_spread_i;
  assign rev_shift = LogW'(MaxLogSpread) - eff_log;
  assign rev_code  = reverse_idx(code_index_i) >> rev_shift;
  assign high_bits = code_index_i >> eff_log;

  assign chip_o       = gold_bit_i ^ (^(pos_low_i & rev_code));
  assign bad_config_o = too_large || (high_bits != '0);

endmodule

>>> rtl/gold_ovsf_spreading_code_generator.sv
// Top level of the Gold/OVSF spreading code generator: configuration
// registers, the two LFSRs, chip counter and a two-entry output stage.
// Depends on gosc_pkg and gosc_chip_calc.
// Each accepted item steps the LFSRs and counter; its chip is registered.
// Throughput: one item per cycle while the skid entry is empty.
// Reset: asynchronous, active low; registers take their reset values and the
// output stage empties. No clearing pass is needed.
module gold_ovsf_spreading_code_generator import gosc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,  // [0] restart, [7:1] zero
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,  // [0] chip, [7:1] zero
  output logic                m_axis_tlast,
  output logic                m_axis_tuser   // [0] bad_config
);

  logic [LfsrBits-1:0] gold_seed_q;
  logic [IdxW-1:0]     code_index_q;
  logic [LogW-1:0]     log_spread_q;
  logic [LfsrBits-1:0] seq_len_q;

  logic [LfsrBits-1:0] lfsr_fixed_q, lfsr_fixed_d;
  logic [LfsrBits-1:0] lfsr_seeded_q, lfsr_seeded_d;
  logic [LfsrBits-1:0] pos_q, pos_d;

  logic [LfsrBits-1:0] cur_fixed, cur_seeded, cur_pos;
  logic                restart, s_acc, fb_fixed, fb_seeded;
  result_t             res_new;
  result_t             out_q, skid_q;
  logic                out_valid_q, skid_valid_q;

  assign s_axis_tready = !skid_valid_q;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign restart       = s_axis_tdata[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gold_seed_q  <= LfsrBits'(1);
      code_index_q <= '0;
      log_spread_q <= '0;
      seq_len_q    <= LfsrBits'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CfgGoldSeed:  gold_seed_q  <= cfg_wdata_i[LfsrBits-1:0];
        CfgCodeIndex: code_index_q <= cfg_wdata_i[IdxW-1:0];
        CfgLogSpread: log_spread_q <= cfg_wdata_i[LogW-1:0];
        CfgSeqLength: seq_len_q    <= cfg_wdata_i[LfsrBits-1:0];
      endcase
    end
  end

  assign cur_fixed  = restart ? LfsrBits'(1) : lfsr_fixed_q;
  assign cur_seeded = restart ? gold_seed_q  : lfsr_seeded_q;
  assign cur_pos    = restart ? '0           : pos_q;

  gosc_chip_calc u_chip_calc (
    .gold_bit_i   (cur_fixed[0] ^ cur_seeded[0]),
    .pos_low_i    (cur_pos[IdxW-1:0]),
    .code_index_i (code_index_q),
    .log_spread_i (log_spread_q),
    .chip_o       (res_new.chip),
    .bad_config_o (res_new.bad_config)
  );

  assign res_new.last = cur_pos == (seq_len_q - LfsrBits'(1));
  assign fb_fixed     = cur_fixed[3] ^ cur_fixed[0];
  assign fb_seeded    = cur_seeded[3] ^ cur_seeded[2] ^ cur_seeded[1] ^ cur_seeded[0];

  always_comb begin
    if (res_new.last) begin
      lfsr_fixed_d  = LfsrBits'(1);
      lfsr_seeded_d = gold_seed_q;
      pos_d         = '0;
    end else begin
      lfsr_fixed_d  = {fb_fixed, cur_fixed[LfsrBits-1:1]};
      lfsr_seeded_d = {fb_seeded, cur_seeded[LfsrBits-1:1]};
      pos_d         = cur_pos + LfsrBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_fixed_q  <= LfsrBits'(1);
      lfsr_seeded_q <= LfsrBits'(1);
      pos_q         <= '0;
    end else if (s_acc) begin
      lfsr_fixed_q  <= lfsr_fixed_d;
      lfsr_seeded_q <= lfsr_seeded_d;
      pos_q         <= pos_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= s_acc;
      end
    end else if (s_acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || m_axis_tready) begin
      out_q <= skid_valid_q ? skid_q : res_new;
    end else if (s_acc) begin
      skid_q <= res_new;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_q.chip};
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tuser  = out_q.bad_config;

`ifndef SYNTHESIS
  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("Skid entry held while output stage is empty.");

  a_fixed_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lfsr_fixed_q != '0)
    else $error("Fixed LFSR reached the all-zero state.");

  a_restart_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && s_axis_tdata[0] && seq_len_q != LfsrBits'(1) |=> pos_q == LfsrBits'(1))
    else $error("Chip position wrong after a restart item.");

  a_hold_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_acc |=> $stable(lfsr_fixed_q) && $stable(lfsr_seeded_q) && $stable(pos_q))
    else $error("Generator state moved without an accepted item.");
`endif

endmodule

>>> sim/gold_ovsf_spreading_code_generator_tb.sv
// Testbench for the Gold/OVSF spreading code generator: drives items with restart flags
// in bursts, stalls the result side and checks each chip, last and bad_config against a predictor.
// Depends on gosc_pkg and gold_ovsf_spreading_code_generator.
module gold_ovsf_spreading_code_generator_tb import gosc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 200000;
  localparam logic [CfgDataW-1:0] SeedAllOnes = 25'h1FF_FFFF;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = CfgGoldSeed;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = '0;   // [0] restart, [7:1] zero
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;        // [0] chip, [7:1] zero
  logic                m_axis_tlast;
  logic                m_axis_tuser;        // [0] bad_config

  gold_ovsf_spreading_code_generator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  logic [CfgDataW-1:0] seed_r;
  logic [IdxW-1:0]     code_idx_r;
  logic [LogW-1:0]     log_sf_r;
  logic [CfgDataW-1:0] seq_len_r;
  logic [LfsrBits-1:0] lfsr_a;
  logic [LfsrBits-1:0] lfsr_b;
  logic [LfsrBits-1:0] chip_pos;

  result_t     chips_due[$];
  logic        restart_queue[$];
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  logic        s_taken = 1'b0;
  int unsigned gap_max = 0;
  int unsigned gap_left = 0;
  int unsigned burst_left = 0;
  int unsigned stall_mode = 0;
  int unsigned hold_reqs = 0;
  int unsigned hold_served = 0;
  int unsigned hold_cnt = 0;
  logic [7:0]  stall_pat = 8'b1011_0110;

  initial begin
    forever begin
      #2 clk_i = ~clk_i;
    end
  end

  function automatic void reload_gens();
    lfsr_a   = 25'd1;
    lfsr_b   = seed_r;
    chip_pos = '0;
  endfunction

  function automatic result_t next_chip(input logic restart);
    int unsigned     eff;
    logic [8:0]      mask9;
    logic [IdxW-1:0] mask;
    logic [IdxW-1:0] idx;
    logic [IdxW-1:0] rev;
    logic            fb_a;
    logic            fb_b;
    result_t         r;
    if (restart) begin
      reload_gens();
    end
    r.bad_config = 1'b0;
    eff = {28'd0, log_sf_r};
    if (eff > MaxLogSpread) begin
      eff = MaxLogSpread;
      r.bad_config = 1'b1;
    end
    mask9 = (9'd1 << eff) - 9'd1;
    mask = mask9[IdxW-1:0];
    if (code_idx_r > mask) begin
      r.bad_config = 1'b1;
    end
    idx = code_idx_r & mask;
    rev = '0;
    for (int i = 0; i < IdxW; i++) begin
      if (i < eff) begin
        rev[eff-1-i] = idx[i];
      end
    end
    r.chip = lfsr_a[0] ^ lfsr_b[0] ^ (^(chip_pos[IdxW-1:0] & mask & rev));
    r.last = (chip_pos == LfsrBits'(seq_len_r - 25'd1));
    if (r.last) begin
      reload_gens();
    end else begin
      fb_a = lfsr_a[3] ^ lfsr_a[0];
      fb_b = lfsr_b[3] ^ lfsr_b[2] ^ lfsr_b[1] ^ lfsr_b[0];
      lfsr_a = {fb_a, lfsr_a[LfsrBits-1:1]};
      lfsr_b = {fb_b, lfsr_b[LfsrBits-1:1]};
      chip_pos = chip_pos + 25'd1;
    end
    return r;
  endfunction

  always @(negedge clk_i) begin
    logic       nxt_valid;
    logic [7:0] nxt_data;
    nxt_valid = s_axis_tvalid;
    nxt_data  = s_axis_tdata;
    if (!s_axis_tvalid || s_taken) begin
      nxt_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (restart_queue.size() > 0) begin
        nxt_valid = 1'b1;
        nxt_data  = {7'd0, restart_queue.pop_front()};
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 15);
          gap_left   = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
        end
      end
    end
    s_axis_tvalid <= nxt_valid;
    s_axis_tdata  <= nxt_data;
  end

  always @(negedge clk_i) begin
    logic rdy;
    if (hold_served != hold_reqs) begin
      hold_served++;
      hold_cnt = 80;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      rdy = 1'b0;
    end else begin
      case (stall_mode)
        0: rdy = 1'b1;
        1: rdy = ($urandom_range(0, 3) != 0);
        2: begin
          rdy = stall_pat[0];
          stall_pat = {stall_pat[0], stall_pat[7:1]};
        end
        default: rdy = ($urandom_range(0, 1) != 0);
      endcase
    end
    m_axis_tready <= rdy;
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      s_taken <= s_axis_tvalid && s_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        if (chips_due.size() == 0) begin
          $display("%0t: unexpected result chip %0b last %0b bad_config %0b", $time,
                   m_axis_tdata[0], m_axis_tlast, m_axis_tuser);
          err_cnt++;
        end else begin
          want = chips_due.pop_front();
          if (m_axis_tdata[0] !== want.chip) begin
            $display("%0t: chip expected %0b actual %0b", $time, want.chip, m_axis_tdata[0]);
            err_cnt++;
          end
          if (m_axis_tlast !== want.last) begin
            $display("%0t: last expected %0b actual %0b", $time, want.last, m_axis_tlast);
            err_cnt++;
          end
          if (m_axis_tuser !== want.bad_config) begin
            $display("%0t: bad_config expected %0b actual %0b", $time, want.bad_config,
                     m_axis_tuser);
            err_cnt++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        chips_due.push_back(next_chip(s_axis_tdata[0]));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CfgGoldSeed:  seed_r = val;
      CfgCodeIndex: code_idx_r = val[IdxW-1:0];
      CfgLogSpread: log_sf_r = val[LogW-1:0];
      default:      seq_len_r = val;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_all(input logic [CfgDataW-1:0] seed, input logic [IdxW-1:0] idx,
                         input logic [LogW-1:0] lsf, input logic [CfgDataW-1:0] len);
    write_reg(CfgGoldSeed, seed);
    write_reg(CfgCodeIndex, CfgDataW'(idx));
    write_reg(CfgLogSpread, CfgDataW'(lsf));
    write_reg(CfgSeqLength, len);
  endtask

  task automatic wait_drained();
    while (restart_queue.size() > 0 || s_axis_tvalid || chips_due.size() > 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  task automatic send(input logic restart);
    restart_queue.push_back(restart);
  endtask

  initial begin
    logic [CfgDataW-1:0] seed;
    logic [CfgDataW-1:0] len;
    logic [LogW-1:0]     lsf;
    logic [IdxW-1:0]     idx;
    int unsigned         eff;
    int unsigned         restart_pct;

    seed_r     = 25'd1;
    code_idx_r = '0;
    log_sf_r   = '0;
    seq_len_r  = 25'd1;
    reload_gens();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // Directed part: reset values, sequence wrap, reload and every flagged setting.
    send(1'b0); send(1'b0); send(1'b1);
    wait_drained();
    set_all(SeedAllOnes, 8'd5, 4'd3, 25'd5);
    send(1'b0); send(1'b0); send(1'b0); send(1'b0); send(1'b0); send(1'b0);
    send(1'b1); send(1'b0); send(1'b0);
    wait_drained();
    set_all(25'h0AB_CDE1, 8'd9, 4'd3, 25'd0);
    send(1'b1); send(1'b0); send(1'b0);
    wait_drained();
    set_all(25'd0, 8'd255, 4'd15, SeedAllOnes);
    send(1'b1); send(1'b0); send(1'b0);
    wait_drained();
    write_reg(CfgGoldSeed, 25'h0AA_AAAA);
    write_reg(CfgLogSpread, 25'd8);
    send(1'b0); send(1'b0); send(1'b1); send(1'b0);
    wait_drained();

    for (int ph = 0; ph < 14; ph++) begin
      case ($urandom_range(0, 7))
        0:       seed = '0;
        1:       seed = SeedAllOnes;
        default: seed = CfgDataW'($urandom()) & SeedAllOnes;
      endcase
      lsf = LogW'(($urandom_range(0, 9) < 8) ? $urandom_range(0, 8) : $urandom_range(9, 15));
      eff = (lsf > LogW'(MaxLogSpread)) ? MaxLogSpread : {28'd0, lsf};
      idx = IdxW'(($urandom_range(0, 3) != 0) ? $urandom_range(0, (1 << eff) - 1)
                                              : $urandom_range(0, 255));
      case ($urandom_range(0, 9))
        0:       len = '0;
        1:       len = SeedAllOnes;
        2:       len = 25'd1;
        default: len = CfgDataW'($urandom_range(2, 300));
      endcase
      set_all(seed, idx, lsf, len);
      restart_pct = $urandom_range(0, 8);
      gap_max     = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      stall_mode  = $urandom_range(0, 3);
      repeat (130) send($urandom_range(0, 99) < restart_pct);
      if (ph % 4 == 1) begin
        hold_reqs++;
      end
      wait_drained();
    end

    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
